/* rtl/hvn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hvn_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 32;
  localparam int HALF_GRID = GRID_SIZE / 2;
  localparam int WIN_DEPTH = 2 * GRID_SIZE + 1;
  localparam int ADDR_W    = $clog2(WIN_DEPTH);
  localparam int RC_W      = $clog2(GRID_SIZE);
  localparam int P_W       = $clog2(GRID_SIZE + 1);

  // Field widths
  localparam int HEIGHT_W   = 16;
  localparam int POS_W      = 7;
  localparam int NORM_W     = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 2 * POS_W + HEIGHT_W + 3 * NORM_W + 2;

  // Normal arithmetic widths
  localparam int COMP_W      = 20;                // signed X or Z sum of neighbors
  localparam int MAG_W       = 19;                // magnitude of X or Z
  localparam int SQ_W        = 2 * MAG_W;         // squared component
  localparam int SUM_W       = SQ_W + 1;          // squared length
  localparam int FRAC_SHIFT  = 30;                // scale of (2^14)^2 * 4
  localparam int ROOT_W      = SUM_W + FRAC_SHIFT + 3;
  localparam int K_W         = 16;                // root digit register
  localparam int CNT_W       = $clog2(K_W);
  localparam int NQ_W        = 15;                // rounded magnitude, up to 2^14

  localparam logic [NORM_W-1:0] Q14_ONE = NORM_W'(16384);
  localparam logic [SQ_W-1:0]   Y_SQ    = SQ_W'(1536 * 1536);

endpackage

`default_nettype wire

/* rtl/hvn_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/hvn_root.sv */
`timescale 1ns / 1ps
`default_nettype none

// Finds r = floor(sqrt(c2 * 2^30 / s)) one bit per cycle, MSB first, and
// returns (r + 1) / 2, i.e. round(16384 * |c| / sqrt(s)) with ties away from zero.
module hvn_root (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hvn_pkg::SUM_W-1:0] s_i,
  input  logic [hvn_pkg::SQ_W-1:0]  c2_i,
  output logic                      done_o,
  output logic [hvn_pkg::NQ_W-1:0]  m_o
);
  import hvn_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ROOT_W-1:0] a_q;   // c2 * 2^30
  logic [ROOT_W-1:0] p_q;   // k^2 * s
  logic [ROOT_W-1:0] f_q;   // k * s * 2^(b+1)
  logic [ROOT_W-1:0] e_q;   // s * 2^(2b)
  logic [K_W-1:0]    k_q;
  logic [ROOT_W-1:0] cand;
  logic              take;
  logic [K_W-1:0]    k_inc;

  // Trial square for the current bit
  assign cand  = p_q + f_q + e_q;
  assign take  = (cand <= a_q);
  assign k_inc = k_q + K_W'(1);

  // Sequence the bit steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(K_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Update the partial square and shift in one root bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= ROOT_W'(c2_i) << FRAC_SHIFT;
      e_q <= ROOT_W'(s_i) << FRAC_SHIFT;
      f_q <= '0;
      p_q <= '0;
      k_q <= '0;
    end else if (busy_q) begin
      e_q <= e_q >> 2;
      k_q <= {k_q[K_W-2:0], take};
      if (take) begin
        p_q <= cand;
        f_q <= (f_q + (e_q << 1)) >> 1;
      end else begin
        f_q <= f_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign m_o    = k_inc[NQ_W:1];

endmodule

`default_nettype wire

/* rtl/heightfield_vertex_normal_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// A border vertex reads its center height and loads the result; an inner vertex reads
// its window taps, squares X and Z, sums, runs the bit-serial root for X, Y and Z and
// loads the result. One item in flight: no height is accepted until the result is loaded;
// a first-row item gives no result; the final item of a grid adds GRID_SIZE border results.
// Reset: asynchronous, active low; clears counters and handshakes. The height window RAM
// is not cleared and gets no clearing pass; no entry is read before it is written.
module heightfield_vertex_normal_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [hvn_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [15:0] height
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [6:0] pos_x, [13:7] pos_z, [29:14] pos_y, [45:30] normal_x, [61:46] normal_y,
  // [77:62] normal_z, [78] tex_u, [79] tex_v
  output logic [hvn_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o   // last_of_run
);
  import hvn_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_SQX  = 7'b0000100,
    S_SQZ  = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  // Window taps: center, left, up, up-right, right, down, down-left
  localparam logic [2:0] TAP_CTR = 3'd0;
  localparam logic [2:0] TAP_L   = 3'd1;
  localparam logic [2:0] TAP_U   = 3'd2;
  localparam logic [2:0] TAP_UR  = 3'd3;
  localparam logic [2:0] TAP_R   = 3'd4;
  localparam logic [2:0] TAP_D   = 3'd5;
  localparam logic [2:0] TAP_DL  = 3'd6;
  localparam logic [2:0] TAP_ALL = 3'd7;
  localparam logic [2:0] TAP_ONE = 3'd1;

  localparam logic [ADDR_W-1:0] OFF_L  = ADDR_W'(GRID_SIZE + 1);
  localparam logic [ADDR_W-1:0] OFF_U  = ADDR_W'(2 * GRID_SIZE);
  localparam logic [ADDR_W-1:0] OFF_UR = ADDR_W'(2 * GRID_SIZE - 1);
  localparam logic [ADDR_W-1:0] OFF_R  = ADDR_W'(GRID_SIZE - 1);
  localparam logic [ADDR_W-1:0] OFF_D  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] OFF_DL = ADDR_W'(1);

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic [RC_W-1:0] LAST_RC = RC_W'(GRID_SIZE - 1);
  localparam logic [P_W-1:0]  P_CTR   = P_W'(GRID_SIZE);
  localparam logic [P_W-1:0]  P_FLUSH = P_W'(GRID_SIZE - 1);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] wp_q, wp_next;
  logic [RC_W-1:0]   in_row_q, in_col_q;
  logic [RC_W-1:0]   row_q, col_q;
  logic [P_W-1:0]    p_q;
  logic              flush_pending_q, flushing_q;
  logic [2:0]        tap_q, tap_prev, n_tap;
  logic [1:0]        comp_q;
  logic              start_q;
  logic              out_valid_q;
  logic              out_free;
  logic              in_acc;
  logic              inner;
  logic              more;
  logic              read_end;

  logic [ADDR_W-1:0]   tap_off;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W:0]     rd_wrap;
  logic                rd_en;
  logic [HEIGHT_W-1:0] rdata;

  logic signed [COMP_W-1:0] h1, h2;
  logic signed [COMP_W-1:0] x_q, z_q;
  logic [COMP_W-1:0]        x_abs, z_abs;
  logic [MAG_W-1:0]         mul_in;
  logic [SQ_W-1:0]          sq;
  logic [SQ_W-1:0]          x2_q, z2_q, root_c2;
  logic [SUM_W-1:0]         s_q;
  logic                     x_neg_q, z_neg_q;
  logic                     root_done;
  logic [NQ_W-1:0]          root_m;
  logic [NORM_W-1:0]        m_pos;
  logic [HEIGHT_W-1:0]      pos_y_q;
  logic [NORM_W-1:0]        nx_q, ny_q, nz_q;
  logic [OUT_DATA_W-1:0]    out_data_q;
  logic                     out_last_q;
  logic [POS_W-1:0]         pos_x, pos_z;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign wp_next         = (wp_q == ADDR_W'(WIN_DEPTH - 1)) ? '0 : wp_q + 1'b1;

  // Vertex classification and read sequencing
  assign inner    = (row_q != '0) && (col_q != '0) && (row_q != LAST_RC) &&
                    (col_q != LAST_RC) && (p_q == P_CTR);
  assign n_tap    = inner ? TAP_ALL : TAP_ONE;
  assign tap_prev = tap_q - 3'd1;
  assign read_end = (state_q == S_READ) && (tap_q == n_tap);
  assign rd_en    = (state_q == S_READ) && (tap_q < n_tap);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign more     = flush_pending_q || (flushing_q && (col_q != LAST_RC));

  // Select the window offset of the current tap
  always_comb begin
    unique case (tap_q)
      TAP_CTR: tap_off = ADDR_W'(p_q);
      TAP_L:   tap_off = OFF_L;
      TAP_U:   tap_off = OFF_U;
      TAP_UR:  tap_off = OFF_UR;
      TAP_R:   tap_off = OFF_R;
      TAP_D:   tap_off = OFF_D;
      TAP_DL:  tap_off = OFF_DL;
      default: tap_off = '0;
    endcase
  end

  // Map age to a circular buffer address
  assign rd_wrap = {1'b0, wp_q} + (ADDR_W + 1)'(WIN_DEPTH) - {1'b0, tap_off};
  assign rd_addr = (wp_q >= tap_off) ? (wp_q - tap_off) : rd_wrap[ADDR_W-1:0];

  hvn_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_next),
    .wdata_i (s_axis_tdata_i[HEIGHT_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign h1 = COMP_W'($signed(rdata));
  assign h2 = h1 <<< 1;

  // Square one component magnitude per cycle
  assign x_abs  = x_q[COMP_W-1] ? COMP_W'(-x_q) : COMP_W'(x_q);
  assign z_abs  = z_q[COMP_W-1] ? COMP_W'(-z_q) : COMP_W'(z_q);
  assign mul_in = (state_q == S_SQZ) ? z_abs[MAG_W-1:0] : x_abs[MAG_W-1:0];
  assign sq     = SQ_W'(mul_in) * SQ_W'(mul_in);

  always_comb begin
    unique case (comp_q)
      COMP_X:  root_c2 = x2_q;
      COMP_Y:  root_c2 = Y_SQ;
      default: root_c2 = z2_q;
    endcase
  end

  hvn_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .s_i     (s_q),
    .c2_i    (root_c2),
    .done_o  (root_done),
    .m_o     (root_m)
  );

  assign m_pos = NORM_W'(root_m);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && (in_row_q != '0)) state_d = S_READ;
      S_READ: if (read_end) state_d = inner ? S_SQX : S_OUT;
      S_SQX:  state_d = S_SQZ;
      S_SQZ:  state_d = S_SUM;
      S_SUM:  state_d = S_ROOT;
      S_ROOT: if (root_done && (comp_q == COMP_Z)) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = more ? S_READ : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      wp_q            <= '0;
      in_row_q        <= '0;
      in_col_q        <= '0;
      row_q           <= '0;
      col_q           <= '0;
      p_q             <= '0;
      flush_pending_q <= 1'b0;
      flushing_q      <= 1'b0;
      tap_q           <= '0;
      comp_q          <= COMP_X;
      start_q         <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      // Kick the root unit for the first component and after each finished one but the last
      start_q <= (state_q == S_SUM) ||
                 ((state_q == S_ROOT) && root_done && (comp_q != COMP_Z));
      // Hold the result until taken, load a new one when the slot frees
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            wp_q <= wp_next;
            if (in_col_q == LAST_RC) begin
              in_col_q <= '0;
              in_row_q <= (in_row_q == LAST_RC) ? '0 : in_row_q + 1'b1;
            end else begin
              in_col_q <= in_col_q + 1'b1;
            end
            // Result for the vertex one row above the new height
            row_q           <= in_row_q - 1'b1;
            col_q           <= in_col_q;
            p_q             <= P_CTR;
            flush_pending_q <= (in_row_q == LAST_RC) && (in_col_q == LAST_RC);
            flushing_q      <= 1'b0;
            tap_q           <= '0;
          end
        end
        S_READ: begin
          if (!read_end) begin
            tap_q <= tap_q + 3'd1;
          end
        end
        S_SUM: begin
          comp_q <= COMP_X;
        end
        S_ROOT: begin
          if (root_done && (comp_q != COMP_Z)) begin
            comp_q <= comp_q + 2'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            tap_q <= '0;
            // Advance to the flushed last row, one vertex at a time
            if (flush_pending_q) begin
              flush_pending_q <= 1'b0;
              flushing_q      <= 1'b1;
              row_q           <= LAST_RC;
              col_q           <= '0;
              p_q             <= P_FLUSH;
            end else if (more) begin
              col_q <= col_q + 1'b1;
              p_q   <= p_q - 1'b1;
            end else begin
              flushing_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign pos_x = POS_W'(int'(col_q) - HALF_GRID);
  assign pos_z = POS_W'(HALF_GRID - int'(row_q));

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_READ) && (tap_q != '0)) begin
      unique case (tap_prev)
        TAP_CTR: begin
          pos_y_q <= rdata;
          x_q     <= '0;
          z_q     <= '0;
        end
        TAP_L:  begin x_q <= x_q + h2; z_q <= z_q - h1; end
        TAP_U:  begin x_q <= x_q + h1; z_q <= z_q - h2; end
        TAP_UR: begin x_q <= x_q - h1; z_q <= z_q - h1; end
        TAP_R:  begin x_q <= x_q - h2; z_q <= z_q + h1; end
        TAP_D:  begin x_q <= x_q - h1; z_q <= z_q + h2; end
        TAP_DL: begin x_q <= x_q + h1; z_q <= z_q + h1; end
        default: ;
      endcase
    end
    // Border vertex: straight up
    if (read_end && !inner) begin
      nx_q <= '0;
      ny_q <= Q14_ONE;
      nz_q <= '0;
    end
    if (state_q == S_SQX) begin
      x2_q    <= sq;
      x_neg_q <= x_q[COMP_W-1];
    end
    if (state_q == S_SQZ) begin
      z2_q    <= sq;
      z_neg_q <= z_q[COMP_W-1];
    end
    if (state_q == S_SUM) begin
      s_q <= SUM_W'(x2_q) + SUM_W'(z2_q) + SUM_W'(Y_SQ);
    end
    // Store each normalized component with its sign
    if ((state_q == S_ROOT) && root_done) begin
      unique case (comp_q)
        COMP_X:  nx_q <= x_neg_q ? NORM_W'(-m_pos) : m_pos;
        COMP_Y:  ny_q <= m_pos;
        default: nz_q <= z_neg_q ? NORM_W'(-m_pos) : m_pos;
      endcase
    end
    // Load the output register
    if ((state_q == S_OUT) && out_free) begin
      out_data_q <= {row_q[0], col_q[0], nz_q, ny_q, nx_q, pos_y_q, pos_z, pos_x};
      out_last_q <= !more;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire
